### src/itrd_pkg.sv
// Package: constants and codes for the texture RLE decoder.
`timescale 1ns / 1ps
`default_nettype none
package itrd_pkg;

  localparam int unsigned TexWidth  = 128;
  localparam int unsigned TexHeight = 128;
  localparam int unsigned TexSize   = TexWidth * TexHeight;

  localparam int unsigned TEXEL_W = 15;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned LIT_W   = 9;

  localparam logic [TEXEL_W:0] TEX_SIZE = (TEXEL_W + 1)'(TexSize);

  localparam logic [7:0] LITERAL_MARK = 8'hFF;

  localparam logic [1:0] PH_CODE    = 2'd0;
  localparam logic [1:0] PH_LITERAL = 2'd1;
  localparam logic [1:0] PH_REPEAT  = 2'd2;
  localparam logic [1:0] PH_DONE    = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_SHORT     = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [1:0] ST_TRUNCATED = 2'd3;

endpackage
`default_nettype wire

### src/icon_texture_rle_decoder_core.sv
// Top level: run-length decoder turning 16-bit compressed words into run descriptors.
//
// Takes one compressed word per clock and returns at most one run descriptor per word,
// in the cycle after the word's beat, from a single result register. Decode state
// (phase, word count, texel position, literal and repeat counts) updates when the word
// is accepted, so back-to-back words sustain one word per cycle. The input stalls only
// while the result register holds a descriptor that the output side is stalling. Write
// compressed_words via cfg_we/cfg_data only while the block is idle (unenforced).
`timescale 1ns / 1ps
`default_nettype none
module icon_texture_rle_decoder_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] code_word,
  input  wire logic        first_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [14:0]      texel_offset,
  output logic [15:0]      pixel_value,
  output logic [15:0]      run_length,
  output logic [1:0]       status,
  output logic             finished
);

  logic [15:0] compressed_words;
  logic [1:0]  phase, phase_next;
  logic [15:0] words_consumed, words_consumed_next;
  logic [14:0] texel_position, texel_position_next;
  logic [8:0]  literal_left, literal_left_next;
  logic [15:0] repeat_count, repeat_count_next;

  logic        accept;
  logic        emit;
  logic [14:0] res_offset;
  logic [15:0] res_value;
  logic [15:0] res_length;
  logic [1:0]  res_status;
  logic        res_fin;

  logic [1:0]  cur_phase;
  logic [15:0] cur_wc;
  logic [14:0] cur_tp;
  logic [8:0]  cur_ll;
  logic [15:0] cur_rc;
  logic [15:0] wc_inc;
  logic [8:0]  sub;
  logic        fin;
  logic [8:0]  ll_dec;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    cur_phase = first_word ? itrd_pkg::PH_CODE : phase;
    cur_wc    = first_word ? 16'd0 : words_consumed;
    cur_tp    = first_word ? 15'd0 : texel_position;
    cur_ll    = first_word ? 9'd0 : literal_left;
    cur_rc    = first_word ? 16'd0 : repeat_count;
    wc_inc    = cur_wc + 16'd1;
    sub       = 9'd256 - {1'b0, code_word[7:0]};
    fin       = (wc_inc >= compressed_words);
    ll_dec    = (cur_ll != 9'd0) ? cur_ll - 9'd1 : 9'd0;

    phase_next          = cur_phase;
    words_consumed_next = cur_wc;
    texel_position_next = cur_tp;
    literal_left_next   = cur_ll;
    repeat_count_next   = cur_rc;
    emit       = 1'b0;
    res_offset = cur_tp;
    res_value  = 16'd0;
    res_length = 16'd0;
    res_status = itrd_pkg::ST_OK;
    res_fin    = 1'b1;

    if (cur_phase == itrd_pkg::PH_DONE) begin
      emit = 1'b0;
    end else if (cur_wc >= compressed_words) begin
      phase_next = itrd_pkg::PH_DONE;
    end else begin
      words_consumed_next = wc_inc;
      case (cur_phase)
        itrd_pkg::PH_CODE: begin
          if (code_word[15:8] == itrd_pkg::LITERAL_MARK) begin
            if (({1'b0, wc_inc} + {8'd0, sub}) > {1'b0, compressed_words}) begin
              emit       = 1'b1;
              res_status = itrd_pkg::ST_SHORT;
              phase_next = itrd_pkg::PH_DONE;
            end else if (({1'b0, cur_tp} + {7'd0, sub}) > itrd_pkg::TEX_SIZE) begin
              emit       = 1'b1;
              res_status = itrd_pkg::ST_OVERFLOW;
              phase_next = itrd_pkg::PH_DONE;
            end else begin
              literal_left_next = sub;
              phase_next        = itrd_pkg::PH_LITERAL;
            end
          end else if (fin) begin
            emit       = 1'b1;
            res_status = itrd_pkg::ST_TRUNCATED;
            phase_next = itrd_pkg::PH_DONE;
          end else if (({2'b0, cur_tp} + {1'b0, code_word}) > {1'b0, itrd_pkg::TEX_SIZE}) begin
            emit       = 1'b1;
            res_status = itrd_pkg::ST_OVERFLOW;
            phase_next = itrd_pkg::PH_DONE;
          end else begin
            repeat_count_next = code_word;
            phase_next        = itrd_pkg::PH_REPEAT;
          end
        end
        itrd_pkg::PH_LITERAL: begin
          emit                = 1'b1;
          res_value           = code_word;
          res_length          = 16'd1;
          res_fin             = fin;
          texel_position_next = cur_tp + 15'd1;
          literal_left_next   = ll_dec;
          if (fin) begin
            phase_next = itrd_pkg::PH_DONE;
          end else if (ll_dec == 9'd0) begin
            phase_next = itrd_pkg::PH_CODE;
          end else begin
            phase_next = itrd_pkg::PH_LITERAL;
          end
        end
        itrd_pkg::PH_REPEAT: begin
          emit                = 1'b1;
          res_value           = code_word;
          res_length          = cur_rc;
          res_fin             = fin;
          texel_position_next = cur_tp + cur_rc[14:0];
          repeat_count_next   = 16'd0;
          phase_next          = fin ? itrd_pkg::PH_DONE : itrd_pkg::PH_CODE;
        end
        default: begin
          phase_next = itrd_pkg::PH_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      compressed_words <= 16'd0;
      phase            <= itrd_pkg::PH_CODE;
      words_consumed   <= 16'd0;
      texel_position   <= 15'd0;
      literal_left     <= 9'd0;
      repeat_count     <= 16'd0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        compressed_words <= cfg_data;
      end
      if (accept) begin
        phase          <= phase_next;
        words_consumed <= words_consumed_next;
        texel_position <= texel_position_next;
        literal_left   <= literal_left_next;
        repeat_count   <= repeat_count_next;
        out_valid      <= emit;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      texel_offset <= res_offset;
      pixel_value  <= res_value;
      run_length   <= res_length;
      status       <= res_status;
      finished     <= res_fin;
    end
  end

  a_texel_in_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, texel_position} <= itrd_pkg::TEX_SIZE)
    else $error("texel position past end of texture");

  a_error_finishes: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != itrd_pkg::ST_OK |-> finished)
    else $error("error descriptor without finished");

  a_code_no_literal: assert property (@(posedge clk) disable iff (rst)
    phase == itrd_pkg::PH_CODE |-> literal_left == 9'd0)
    else $error("literal count left over in code phase");

  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    accept && phase == itrd_pkg::PH_DONE && !first_word |=> !out_valid)
    else $error("descriptor emitted after decode finished");

endmodule
`default_nettype wire
